@@ hdl/bpe_pkg.sv @@
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared constants and codes for the Bezier point evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

  // default sizing
  localparam int MAX_POINTS_DEF    = 16;
  localparam int COORD_BITS_DEF    = 24;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed field widths
  localparam int PIDX_W      = 4;   // point_index
  localparam int PCOUNT_W    = 5;   // point_count register
  localparam int CFG_DATA_W  = 5;   // widest register
  localparam int CFG_INDEX_W = 1;

  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = PCOUNT_W'(4);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_POINT_COUNT = 1'b0,
    CFG_THREE_D     = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_TOO_FEW  = 1'b1;

endpackage

@@ hdl/bpe_if.sv @@
// ----------------------------------------------------------------------------
// bpe_in_if / bpe_out_if
// Valid/ready channels of the Bezier point evaluator.
// ----------------------------------------------------------------------------
interface bpe_in_if #(
  parameter int COORD_BITS    = bpe_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = bpe_pkg::FRACTION_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  bpe_pkg::cmd_t                   cmd;
  logic [bpe_pkg::PIDX_W-1:0]      point_index;
  logic signed [COORD_BITS-1:0]    coord_x;
  logic signed [COORD_BITS-1:0]    coord_y;
  logic signed [COORD_BITS-1:0]    coord_z;
  logic [FRACTION_BITS:0]          fraction;

  modport source (output valid, cmd, point_index, coord_x, coord_y, coord_z, fraction,
                  input ready);
  modport sink   (input valid, cmd, point_index, coord_x, coord_y, coord_z, fraction,
                  output ready);
endinterface

interface bpe_out_if #(
  parameter int COORD_BITS = bpe_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] res_x;
  logic signed [COORD_BITS-1:0] res_y;
  logic signed [COORD_BITS-1:0] res_z;
  logic                         status;

  modport source (output valid, res_x, res_y, res_z, status, input ready);
  modport sink   (input valid, res_x, res_y, res_z, status, output ready);
endinterface

@@ hdl/bezier_point_evaluator.sv @@
// ----------------------------------------------------------------------------
// bezier_point_evaluator
// Loads control points into a store and evaluates a Bezier curve point by
// repeated linear interpolation (De Casteljau) on one shared lerp unit.
// ----------------------------------------------------------------------------
//
//   channel  | dir | beat contents                                | handshake
//   ---------+-----+----------------------------------------------+-------------
//   in_ch    | in  | cmd, point_index, coord_x/y/z, fraction      | valid/ready
//   out_ch   | out | res_x, res_y, res_z, status                  | valid/ready
//   cfg_*    | in  | cfg_index, cfg_wdata                         | cfg_we only
//
// A load beat is written into the store as it is accepted. An evaluate runs
//   its axes (three with three_d set, else two) on the single lerp unit, one
//   lerp or one queue shift per cycle. Fewer than two points go straight to
//   the result, with status too-few.
// Reset (rst_n low, synchronous) clears the sequencer and the output valid,
//   sets point_count to 4 and three_d to 0; the point store is not cleared.
// in_ch is ready only while idle. A finished result waits in the sequencer
//   until the output register is free, so a stalled out_ch holds one result
//   and still lets the next item in.
// ----------------------------------------------------------------------------
module bezier_point_evaluator #(
  parameter int MAX_POINTS    = bpe_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS    = bpe_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = bpe_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  bpe_in_if.sink                             in_ch,
  bpe_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  bpe_pkg::cfg_reg_t                  cfg_index,
  input  logic [bpe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import bpe_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int L  = MAX_POINTS;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int IW = (AW > PIDX_W) ? AW : PIDX_W;
  localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

  // axis codes; lanes shift down so the active axis always sits in lane 0
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FILL = 4'b0010,
    ST_CALC = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // config registers
  logic [PCOUNT_W-1:0] point_count_r;
  logic                three_d_r;

  // sequencer
  state_t        state_r, state_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [NW-1:0] m_r, m_nxt;          // entries in the current round
  logic [NW-1:0] step_r, step_nxt;    // step within the round
  logic [1:0]    axis_r, axis_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload
  logic [F:0]            t_r;
  logic signed [C-1:0]   res_x_r, res_y_r, res_z_r;
  logic                  res_status_r;
  logic signed [C-1:0]   out_x_r, out_y_r, out_z_r;
  logic                  out_status_r;

  // point store {x, y, z} and the working lanes
  logic [3*C-1:0]        pts_mem_r [MAX_POINTS];
  logic [3*C-1:0]        rd_data_r;
  logic [AW-1:0]         rd_addr;
  logic signed [C-1:0]   lane0_r [L];
  logic signed [C-1:0]   lane1_r [L];
  logic signed [C-1:0]   lane2_r [L];

  logic                  in_acc;
  logic                  is_load;
  logic                  load_we;
  logic [IW-1:0]         idx_ext;
  logic [NW-1:0]         n_clamp;
  logic                  too_few;
  logic [F:0]            t_clamp;
  logic [NW-1:0]         m_last;
  logic                  round_end;
  logic                  axis_end;
  logic [1:0]            last_axis;
  logic                  out_free;
  logic signed [C-1:0]   lerp_y;

  // --------------------------------------------------------------------------
  // decode
  // --------------------------------------------------------------------------
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_load     = (in_ch.cmd == CMD_LOAD);
  assign idx_ext     = IW'(in_ch.point_index);
  assign load_we     = in_acc && is_load && (int'(in_ch.point_index) < MAX_POINTS);

  assign n_clamp = (int'(point_count_r) > MAX_POINTS) ? NW'(MAX_POINTS)
                                                      : NW'(point_count_r);
  assign too_few = (n_clamp < NW'(2));
  assign t_clamp = (in_ch.fraction > T_ONE) ? T_ONE : in_ch.fraction;

  assign m_last    = m_r - NW'(1);
  assign round_end = (step_r == m_last);
  assign axis_end  = round_end && (m_r == NW'(2));
  assign last_axis = three_d_r ? AXIS_Z : AXIS_Y;
  assign out_free  = !out_valid_r || out_ch.ready;

  assign rd_addr = (fill_cnt_r < n_r) ? fill_cnt_r[AW-1:0] : '0;

  // shared interpolation unit, always on the head of lane 0
  bpe_lerp #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lerp (
    .a (lane0_r[0]),
    .b (lane0_r[1]),
    .t (t_r),
    .y (lerp_y)
  );

  // --------------------------------------------------------------------------
  // config port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= PCOUNT_RESET;
      three_d_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POINT_COUNT: point_count_r <= cfg_wdata[PCOUNT_W-1:0];
        CFG_THREE_D:     three_d_r     <= cfg_wdata[0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    fill_cnt_nxt  = fill_cnt_r;
    m_nxt         = m_r;
    step_nxt      = step_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && !is_load) begin
          if (too_few) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt    = ST_FILL;
            n_nxt        = n_clamp;
            fill_cnt_nxt = '0;
            axis_nxt     = AXIS_X;
          end
        end
      end
      ST_FILL: begin
        if (fill_cnt_r == n_r) begin
          state_nxt = ST_CALC;
          m_nxt     = n_r;
          step_nxt  = '0;
        end else begin
          fill_cnt_nxt = fill_cnt_r + NW'(1);
        end
      end
      ST_CALC: begin
        if (!round_end) begin
          step_nxt = step_r + NW'(1);
        end else if (!axis_end) begin
          step_nxt = '0;
          m_nxt    = m_last;
        end else if (axis_r == last_axis) begin
          state_nxt = ST_DONE;
        end else begin
          axis_nxt = axis_r + 2'd1;
          m_nxt    = n_r;
          step_nxt = '0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      fill_cnt_r  <= '0;
      m_r         <= '0;
      step_r      <= '0;
      axis_r      <= AXIS_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      m_r         <= m_nxt;
      step_r      <= step_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // point store: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (load_we) begin
      pts_mem_r[idx_ext[AW-1:0]] <= {in_ch.coord_x, in_ch.coord_y, in_ch.coord_z};
    end
    rd_data_r <= pts_mem_r[rd_addr];
  end

  // --------------------------------------------------------------------------
  // working lanes
  // Fill: entry k lands in the cycle after its read, from the registered read port.
  // Round of m entries: m-1 lerp steps, each shifting lane 0 left by one and
  // writing the new point at m-1, then one shift that drops the last old
  // point. After the final round the curve coordinate is at lane0[1].
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == ST_FILL) begin
      for (int k = 0; k < L; k++) begin
        if (fill_cnt_r == NW'(k + 1)) begin
          lane0_r[k] <= rd_data_r[3*C-1:2*C];
          lane1_r[k] <= rd_data_r[2*C-1:C];
          lane2_r[k] <= rd_data_r[C-1:0];
        end
      end
    end else if (state_r == ST_CALC) begin
      if (!round_end) begin
        for (int k = 0; k < L; k++) begin
          if (NW'(k) == m_last) begin
            lane0_r[k] <= lerp_y;
          end else if (k < L - 1) begin
            lane0_r[k] <= lane0_r[k + 1];
          end
        end
      end else if (!axis_end) begin
        for (int k = 0; k < L - 1; k++) begin
          lane0_r[k] <= lane0_r[k + 1];
        end
      end else begin
        // axis finished: bring the next axis into lane 0
        for (int k = 0; k < L; k++) begin
          lane0_r[k] <= lane1_r[k];
          lane1_r[k] <= lane2_r[k];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result staging and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc && !is_load) begin
      t_r     <= t_clamp;
      res_x_r <= '0;
      res_y_r <= '0;
      res_z_r <= '0;
      res_status_r <= too_few ? STATUS_TOO_FEW : STATUS_OK;
    end else if (state_r == ST_CALC && axis_end) begin
      if (axis_r == AXIS_X) begin
        res_x_r <= lane0_r[1];
      end
      if (axis_r == AXIS_Y) begin
        res_y_r <= lane0_r[1];
      end
      if (axis_r == AXIS_Z) begin
        res_z_r <= lane0_r[1];
      end
    end
    if (state_r == ST_DONE && out_free) begin
      out_x_r      <= res_x_r;
      out_y_r      <= res_y_r;
      out_z_r      <= res_z_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.res_x  = out_x_r;
  assign out_ch.res_y  = out_y_r;
  assign out_ch.res_z  = out_z_r;
  assign out_ch.status = out_status_r;

endmodule

@@ hdl/bpe_lerp.sv @@
// ----------------------------------------------------------------------------
// bpe_lerp
// One linear interpolation step: a + round((b - a) * t), ties away from zero.
// ----------------------------------------------------------------------------
module bpe_lerp #(
  parameter int COORD_BITS    = bpe_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = bpe_pkg::FRACTION_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] a,
  input  logic signed [COORD_BITS-1:0] b,
  input  logic [FRACTION_BITS:0]       t,
  output logic signed [COORD_BITS-1:0] y
);

  localparam int C = COORD_BITS;
  localparam int F = FRACTION_BITS;
  localparam int PW = C + F + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

  logic signed [C:0] diff;
  logic [C:0]        diff_neg;
  logic              neg;
  logic [C-1:0]      mag;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     prod_rnd;
  logic [C-1:0]      step;
  logic signed [C:0] sum;

  always_comb begin
    diff     = $signed({b[C-1], b}) - $signed({a[C-1], a});
    diff_neg = -diff;
    neg      = diff[C];
    mag      = neg ? diff_neg[C-1:0] : diff[C-1:0];
    prod     = PW'(mag) * PW'(t);
    prod_rnd = prod + HALF;
    step     = prod_rnd[C+F-1:F];
    // magnitude rounded, so ties on negative steps also round away from zero
    if (neg) begin
      sum = $signed({a[C-1], a}) - $signed({1'b0, step});
    end else begin
      sum = $signed({a[C-1], a}) + $signed({1'b0, step});
    end
    y = sum[C-1:0];
  end

endmodule

@@ test/bezier_point_evaluator_tb.sv @@
// ----------------------------------------------------------------------------
// bezier_point_evaluator_tb
// Self-checking bench for the Bezier point evaluator. A clocked driver feeds
// load and evaluate beats from a queue, a clocked monitor takes result beats
// with random back-pressure, and an in-bench De Casteljau predictor supplies
// the expected curve point for every evaluate beat. Configuration changes
// happen only while the block is drained.
// ----------------------------------------------------------------------------
module bezier_point_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpe_pkg::*;

  localparam int MAX_PTS = MAX_POINTS_DEF;
  localparam int COORD_W = COORD_BITS_DEF;
  localparam int FRAC_W  = FRACTION_BITS_DEF;

  localparam longint T_ONE = longint'(1) <<< FRAC_W;
  localparam longint T_HALF = longint'(1) <<< (FRAC_W - 1);

  localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

  // worst evaluate: 16 points in 3D
  localparam int EVAL_WORST = MAX_PTS + 3 + 3 * (MAX_PTS * (MAX_PTS + 1) / 2 - 1);
  localparam int SETTLE_CYCLES = EVAL_WORST + 8;

  // receiver hold-off that backs the block up into its input
  localparam int LONG_HOLD = 1500;
  localparam int HOLD_AT_RESULT = 30;

  // cycles with no beat on either side before the run is declared hung
  localparam int QUIET_LIMIT = 4 * (LONG_HOLD + EVAL_WORST + SETTLE_CYCLES + 40);

  localparam int PHASES = 20;
  localparam int BEATS_PER_PHASE = 96;

  typedef struct {
    cmd_t                       cmd;
    logic [PIDX_W-1:0]          idx;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic [FRAC_W:0]            frac;
  } curve_beat_t;

  typedef struct {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic                       status;
  } curve_point_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  cfg_reg_t                cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  bpe_in_if  in_ch ();
  bpe_out_if out_ch ();

  bezier_point_evaluator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Bench-side copy of the block: point store plus both registers.
  logic signed [COORD_W-1:0] ctrl_pts [MAX_PTS][3];
  logic [PCOUNT_W-1:0]       pcount_cfg;
  logic                      three_d_cfg;

  curve_beat_t  beat_queue[$];     // beats waiting to go out
  curve_point_t curve_expect[$];   // predicted points, oldest first
  curve_beat_t  beat_now;          // beat currently on the input bus

  int  mismatches;
  int  points_seen;
  int  quiet_cycles;
  int  send_gap;
  int  hold_cnt;
  bit  no_idle;                    // per-phase: both sides run back to back

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // One interpolation step, a + round((b - a) * t), ties away from zero.
  function automatic longint lerp_fix(longint a, longint b, longint t);
    longint d;
    d = b - a;
    if (d >= 0) begin
      return a + ((d * t + T_HALF) >>> FRAC_W);
    end
    return a - (((-d) * t + T_HALF) >>> FRAC_W);
  endfunction

  // De Casteljau reduction on one axis over the first n store entries.
  function automatic longint casteljau_axis(int n, int axis, longint t);
    longint w [MAX_PTS];
    for (int i = 0; i < n; i++) begin
      w[i] = ctrl_pts[i][axis];
    end
    for (int r = n - 1; r > 0; r--) begin
      for (int i = 0; i < r; i++) begin
        w[i] = lerp_fix(w[i], w[i+1], t);
      end
    end
    return w[0];
  endfunction

  // Applies one accepted beat: a load updates the store, an evaluate queues
  // the point that the block must return.
  function automatic void apply_beat(curve_beat_t b);
    curve_point_t p;
    int           n;
    longint       t;
    if (b.cmd == CMD_LOAD) begin
      ctrl_pts[b.idx][0] = b.x;
      ctrl_pts[b.idx][1] = b.y;
      ctrl_pts[b.idx][2] = b.z;
      return;
    end
    n = (pcount_cfg > MAX_PTS) ? MAX_PTS : int'(pcount_cfg);
    p.x = '0;
    p.y = '0;
    p.z = '0;
    if (n < 2) begin
      p.status = STATUS_TOO_FEW;
    end else begin
      // t beyond 1.0 saturates
      t = (longint'(b.frac) > T_ONE) ? T_ONE : longint'(b.frac);
      p.x = COORD_W'(casteljau_axis(n, 0, t));
      p.y = COORD_W'(casteljau_axis(n, 1, t));
      if (three_d_cfg) begin
        p.z = COORD_W'(casteljau_axis(n, 2, t));
      end
      p.status = STATUS_OK;
    end
    curve_expect.push_back(p);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_idle();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 40);
  endfunction

  // Coordinates lean on the range ends, zero and small magnitudes.
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return CMAX;
      1: return CMIN;
      2: return '0;
      3: return COORD_W'(int'($urandom_range(0, 600)) - 300);
      default: return COORD_W'($urandom());
    endcase
  endfunction

  // t around its ends, one half, and above one (saturating).
  function automatic logic [FRAC_W:0] pick_frac();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return (FRAC_W+1)'(T_ONE);
      2: return (FRAC_W+1)'($urandom_range(int'(T_ONE) + 1, 2 * int'(T_ONE) - 1));
      3: return (FRAC_W+1)'(T_HALF);
      default: return (FRAC_W+1)'($urandom_range(0, int'(T_ONE) - 1));
    endcase
  endfunction

  task automatic queue_load(int idx, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y,
                            logic signed [COORD_W-1:0] z);
    curve_beat_t b;
    b.cmd  = CMD_LOAD;
    b.idx  = PIDX_W'(idx);
    b.x    = x;
    b.y    = y;
    b.z    = z;
    b.frac = (FRAC_W+1)'($urandom());   // don't-care on loads, kept random
    beat_queue.push_back(b);
  endtask

  task automatic queue_eval(logic [FRAC_W:0] frac);
    curve_beat_t b;
    b.cmd  = CMD_EVAL;
    b.idx  = PIDX_W'($urandom());
    b.x    = COORD_W'($urandom());
    b.y    = COORD_W'($urandom());
    b.z    = COORD_W'($urandom());
    b.frac = frac;
    beat_queue.push_back(b);
  endtask

  // Register write; the bench copy follows since the block is idle.
  task automatic write_reg(cfg_reg_t which, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (which == CFG_POINT_COUNT) begin
      pcount_cfg = PCOUNT_W'(value);
    end else begin
      three_d_cfg = value[0];
    end
  endtask

  // Waits until every beat is sent and every point has come back, then lets
  // a worst-case evaluate's worth of cycles pass before touching registers.
  // Sampled on the falling edge so the driver's updates have settled.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (beat_queue.size() != 0 || in_ch.valid || curve_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: one beat in flight; a stalled beat stays on the bus.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // block is busy, keep offering the same beat
    end else begin
      if (in_ch.valid) begin
        apply_beat(beat_now);
        send_gap = pick_idle();
      end
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (beat_queue.size() != 0) begin
        beat_now = beat_queue.pop_front();
        in_ch.cmd         <= beat_now.cmd;
        in_ch.point_index <= beat_now.idx;
        in_ch.coord_x     <= beat_now.x;
        in_ch.coord_y     <= beat_now.y;
        in_ch.coord_z     <= beat_now.z;
        in_ch.fraction    <= beat_now.frac;
        in_ch.valid       <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compares against the oldest prediction, then decides the
  // next ready. One long hold-off lets the block fill up and stall its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    curve_point_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        points_seen++;
        if (curve_expect.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected point x=%0d y=%0d z=%0d status=%0d", $time,
                   out_ch.res_x, out_ch.res_y, out_ch.res_z, out_ch.status);
        end else begin
          want = curve_expect.pop_front();
          if (out_ch.res_x !== want.x || out_ch.res_y !== want.y ||
              out_ch.res_z !== want.z || out_ch.status !== want.status) begin
            mismatches++;
            $display("%0t: point mismatch expected x=%0d y=%0d z=%0d status=%0d",
                     $time, want.x, want.y, want.z, want.status);
            $display("%0t:                actual x=%0d y=%0d z=%0d status=%0d",
                     $time, out_ch.res_x, out_ch.res_y, out_ch.res_z, out_ch.status);
          end
        end
        hold_cnt = (points_seen == HOLD_AT_RESULT) ? LONG_HOLD : pick_idle();
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without a beat on either channel means a hang.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles > QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed beats, then randomized phases.
  // --------------------------------------------------------------------------
  initial begin
    int pc;
    int flat_or_3d;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_POINT_COUNT;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_LOAD;
    in_ch.point_index = '0;
    in_ch.coord_x     = '0;
    in_ch.coord_y     = '0;
    in_ch.coord_z     = '0;
    in_ch.fraction    = '0;
    out_ch.ready      = 1'b0;
    mismatches        = 0;
    points_seen       = 0;
    quiet_cycles      = 0;
    no_idle           = 1'b0;
    pcount_cfg        = PCOUNT_RESET;
    three_d_cfg       = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: fill the whole store first so no evaluate ever touches an
    // entry that was never written. Neighbors swing between range ends,
    // the hardest case for the interpolation.
    write_reg(CFG_POINT_COUNT, 4);
    write_reg(CFG_THREE_D, 1);
    for (int i = 0; i < MAX_PTS; i++) begin
      queue_load(i, i[0] ? CMIN : CMAX, i[0] ? CMAX : CMIN,
                 COORD_W'((i % 4 == 0) ? 0 : (i % 4 == 1) ? -1 :
                          (i % 4 == 2) ? 1 : int'(CMIN)));
    end
    queue_eval('0);                                     // t = 0
    queue_eval((FRAC_W+1)'(T_ONE));                     // t = 1
    queue_eval((FRAC_W+1)'(T_HALF));                    // t = 1/2
    queue_eval((FRAC_W+1)'(1));                         // smallest step
    queue_eval((FRAC_W+1)'(T_ONE + 1));                 // just above one
    queue_eval('1);                                     // field maximum
    drain();

    // Random phases. The first few hit the register extremes: too few
    // points, more points than the store holds, flat and 3D.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin pc = 0;  flat_or_3d = 1; end
        1: begin pc = 1;  flat_or_3d = 0; end
        2: begin pc = 16; flat_or_3d = 0; end
        3: begin pc = 31; flat_or_3d = 1; end
        4: begin pc = 2;  flat_or_3d = 1; end
        5: begin pc = 17; flat_or_3d = 0; end
        6: begin pc = 3;  flat_or_3d = 0; end
        default: begin
          // keep most curves short, now and then a long one
          pc = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(2, 6);
          flat_or_3d = $urandom_range(0, 1);
        end
      endcase
      write_reg(CFG_POINT_COUNT, pc);
      write_reg(CFG_THREE_D, flat_or_3d);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) < 35) begin
          queue_load($urandom_range(0, MAX_PTS - 1), pick_coord(), pick_coord(),
                     pick_coord());
        end else begin
          queue_eval(pick_frac());
        end
      end
      drain();
    end

    if (curve_expect.size() != 0) begin
      mismatches++;
      $display("%0t: %0d predicted points never arrived", $time, curve_expect.size());
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/bpe_pkg.sv
hdl/bpe_if.sv
hdl/bpe_lerp.sv
hdl/bezier_point_evaluator.sv
test/bezier_point_evaluator_tb.sv
